### src/dmx_pkg.sv
// Package for the DMX512 RGB slot capture block.
// Holds the transaction payload types, widths and the slot counter limit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmx_pkg;

  localparam int unsigned SlotWidth  = 10;
  localparam int unsigned CmpWidth   = SlotWidth + 1;
  localparam logic [SlotWidth-1:0] SlotLimit    = 10'd514;
  localparam logic [SlotWidth-1:0] BaseSlotInit = 10'd1;

  // One received UART byte with its framing-error flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       framing_error;
  } dmx_in_t;

  // One captured color triple.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } dmx_out_t;

endpackage

`default_nettype wire

### src/dmx_rgb_slot_capture.sv
// Top level of the DMX512 RGB slot capture block.
// Depends on dmx_pkg for the payload types and the slot constants.
//
// This block takes the bytes of a DMX512 line, one per input transaction, each with the
// framing-error flag of the UART. A framing-error byte is a break: a zero break byte
// opens a valid frame with the slot counter at 1 (the start code counts as slot 1), a
// nonzero one marks the frame invalid. In a valid frame the bytes at base_slot and
// base_slot+1 are held, and the byte at base_slot+2 emits one output transaction with
// red, green and blue. The counter saturates at 514. base_slot resets to 1 and is written
// through cfg_write/cfg_data; the user must write it only while the block is idle, as the
// block does not enforce this. One byte is accepted every clock cycle while in_stall is
// low; a byte passes through the input register, and its triple is registered in the
// output register. The only loop is the slot counter, frame flag and held-byte update.
`timescale 1ns / 1ps
`default_nettype none

module dmx_rgb_slot_capture (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire dmx_pkg::dmx_in_t                 in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output dmx_pkg::dmx_out_t                     out_item,
  input  wire logic                             cfg_write,
  input  wire logic [dmx_pkg::SlotWidth-1:0]    cfg_data
);
  import dmx_pkg::*;

  logic                 s1_valid;
  dmx_in_t              s1_item;
  logic                 advance;
  logic                 accept;

  logic [SlotWidth-1:0] base_slot;
  logic [SlotWidth-1:0] slot_count;
  logic [SlotWidth-1:0] slot_count_next;
  logic                 frame_valid;
  logic                 frame_valid_next;
  logic [7:0]           held0;
  logic [7:0]           held1;
  logic [7:0]           held0_next;
  logic [7:0]           held1_next;
  logic                 emit;

  logic [CmpWidth-1:0]  slot_ext;
  logic [CmpWidth-1:0]  base0;
  logic [CmpWidth-1:0]  base1;
  logic [CmpWidth-1:0]  base2;

  // The input register moves on whenever the output register is free or being drained.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_item <= in_item;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_slot <= BaseSlotInit;
    end else if (cfg_write) begin
      base_slot <= cfg_data;
    end
  end

  // Slot compares are done one bit wider so that base_slot+2 never wraps.
  assign slot_ext = {1'b0, slot_count};
  assign base0    = {1'b0, base_slot};
  assign base1    = base0 + CmpWidth'(1);
  assign base2    = base0 + CmpWidth'(2);

  // Frame tracking, byte capture and result decision for the item in the input register.
  always_comb begin
    slot_count_next  = slot_count;
    frame_valid_next = frame_valid;
    held0_next       = held0;
    held1_next       = held1;
    emit             = 1'b0;
    if (s1_item.framing_error) begin
      if (s1_item.data_byte == 8'd0) begin
        frame_valid_next = 1'b1;
        slot_count_next  = SlotWidth'(1);
      end else begin
        frame_valid_next = 1'b0;
        slot_count_next  = '0;
      end
    end else if (frame_valid) begin
      if (slot_ext == base0) begin
        held0_next = s1_item.data_byte;
      end
      if (slot_ext == base1) begin
        held1_next = s1_item.data_byte;
      end
      emit = (slot_ext == base2);
      if (slot_count < SlotLimit) begin
        slot_count_next = slot_count + SlotWidth'(1);
      end
    end
  end

  // Frame state registers, updated as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= '0;
      frame_valid <= 1'b0;
      held0       <= '0;
      held1       <= '0;
    end else if (advance) begin
      slot_count  <= slot_count_next;
      frame_valid <= frame_valid_next;
      held0       <= held0_next;
      held1       <= held1_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_item.red   <= held0;
      out_item.green <= held1;
      out_item.blue  <= s1_item.data_byte;
    end
  end

  // The counter is nonzero exactly while a frame is valid.
  a_frame_count : assert property (@(posedge clk) disable iff (rst)
    frame_valid == (slot_count != '0))
    else $error("frame_valid and slot_count disagree");

  // The counter never passes its saturation limit.
  a_count_limit : assert property (@(posedge clk) disable iff (rst)
    slot_count <= SlotLimit)
    else $error("slot_count above limit");

  // A new result only appears after an item left the input register.
  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("output transaction without a processed item");

  // Held bytes and frame state change only when an item is processed.
  a_state_hold : assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(held0) && $stable(held1) && $stable(slot_count))
    else $error("frame state changed without a processed item");

  // Input is stalled only while the input register holds an item that cannot move.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without cause");

endmodule

`default_nettype wire
